// ===== rtl/core/dfs_pkg.sv =====
// Shared types, codes and helper functions for the maze carver.
package dfs_pkg;

    localparam logic CMD_GEN  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_BAD_READ  = 2'd2;

    localparam logic CFG_GRID_SIZE   = 1'b0;
    localparam logic CFG_RANDOM_SEED = 1'b1;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [5:0]  SIZE_RESET = 6'd63;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    // One stack entry: cell, the three swap picks of its shuffle and the next try.
    typedef struct packed {
        logic [5:0] row;
        logic [5:0] col;
        logic       j1;
        logic [1:0] j2;
        logic [1:0] j3;
        logic [2:0] nxt;
    } t_entry;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_OPEN  = 8'b0000_1000,
        S_STEP  = 8'b0001_0000,
        S_TEST  = 8'b0010_0000,
        S_MID   = 8'b0100_0000,
        S_POP   = 8'b1000_0000
    } t_state;

    function automatic logic [15:0] lfsr_step(input logic [15:0] s);
        logic [15:0] t;
        t = {1'b0, s[15:1]};
        if (s[0]) begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

    // Remainder by three: 4^k is 1 mod 3, so fold the bit pairs.
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [2:0] acc;
        acc = 3'd0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + {1'b0, v[2*i +: 2]};
            if (acc >= 3'd3) begin
                acc = acc - 3'd3;
            end
        end
        return acc[1:0];
    endfunction

    function automatic logic [1:0] code_dir(input logic j1, input logic [1:0] j2,
                                            input logic [1:0] j3, input logic [1:0] k);
        logic [1:0] a [4];
        logic [1:0] t;
        a[0] = 2'd0; a[1] = 2'd1; a[2] = 2'd2; a[3] = 2'd3;
        t = a[1]; a[1] = a[{1'b0, j1}]; a[{1'b0, j1}] = t;
        t = a[2]; a[2] = a[j2]; a[j2] = t;
        t = a[3]; a[3] = a[j3]; a[j3] = t;
        return a[k];
    endfunction

endpackage

// ===== rtl/core/dfs_maze_carver.sv =====
// Depth-first maze carver over a bit grid memory with an explicit walk stack.
//
// Input channel (i_in_valid / o_in_stall) takes a command with a row and column.
// A generate command (i_command = 0) rebuilds the maze from the given odd start
// cell; a read command (i_command = 1) returns the wall bit of one cell.
// Output channel (o_out_valid / i_out_stall) gives one result per command:
// o_wall and o_status. A stalled result holds; no new command is taken while
// a result waits and cannot leave in the same cycle.
// A read passes through S_READ, where the registered grid bit is taken, and a
// rejected command's result is registered directly in S_IDLE. A generate first
// sweeps the grid to walls, one cell a cycle, opens the start cell, then walks:
// each try of a direction passes through S_STEP, then S_TEST when the target
// lies inside the border and is read, then S_MID when it is carved; each pop
// passes through S_STEP and S_POP, the last pop only through S_STEP.
// Reset runs the same wall sweep with input stalled; configuration writes are
// taken at any time.
module dfs_maze_carver
    import dfs_pkg::*;
#(
    parameter int MAX_SIDE    = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_wall,
    output logic [1:0]  o_status
);

    localparam int GD  = MAX_SIDE * MAX_SIDE;
    localparam int AW  = $clog2(GD);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int CAP = (MAX_SIDE < 63) ? MAX_SIDE : 63;

    logic        grid_mem [GD];
    t_entry      stack_mem [STACK_DEPTH];

    t_state      r_state, n_state;
    logic [5:0]  r_size;
    logic [15:0] r_seed, r_lfsr, n_lfsr;
    logic [SPW-1:0] r_sp, n_sp;
    t_entry      r_top, n_top;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_gen, n_gen;
    logic [5:0]  r_nr, n_nr, r_nc, n_nc;
    logic [AW-1:0] r_maddr, n_maddr;
    logic        r_ov, n_ov, r_wall, n_wall;
    logic [1:0]  r_status, n_status;

    logic          g_we, g_wd, g_rd;
    logic [AW-1:0] g_waddr, g_raddr;
    logic          s_we;
    logic [SW-1:0] s_waddr, s_raddr;
    t_entry        s_rd;

    logic [5:0]  side;
    logic        out_free, accept, start_bad, read_bad;
    logic [15:0] l1, l2, l3;
    logic [1:0]  dir;
    logic        skip;
    logic [5:0]  nr, nc, mr, mc;

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
        return AW'(32'(r) * MAX_SIDE + 32'(c));
    endfunction

    assign side      = (r_size < 6'(CAP)) ? r_size : 6'(CAP);
    assign out_free  = !r_ov || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept    = i_in_valid && !o_in_stall;
    assign start_bad = !i_row[0] || !i_col[0] || (i_row >= side) || (i_col >= side);
    assign read_bad  = (i_row >= side) || (i_col >= side);

    assign l1 = lfsr_step(r_lfsr);
    assign l2 = lfsr_step(l1);
    assign l3 = lfsr_step(l2);

    // Direction of the current try and its border check.
    always_comb begin
        dir  = code_dir(r_top.j1, r_top.j2, r_top.j3, r_top.nxt[1:0]);
        skip = 1'b0;
        nr = r_top.row; nc = r_top.col; mr = r_top.row; mc = r_top.col;
        case (dir)
            DIR_UP: begin
                skip = (r_top.row <= 6'd2);
                nr = r_top.row - 6'd2; mr = r_top.row - 6'd1;
            end
            DIR_RIGHT: begin
                skip = ({1'b0, r_top.col} + 7'd3 >= {1'b0, side});
                nc = r_top.col + 6'd2; mc = r_top.col + 6'd1;
            end
            DIR_DOWN: begin
                skip = ({1'b0, r_top.row} + 7'd3 >= {1'b0, side});
                nr = r_top.row + 6'd2; mr = r_top.row + 6'd1;
            end
            DIR_LEFT: begin
                skip = (r_top.col <= 6'd2);
                nc = r_top.col - 6'd2; mc = r_top.col - 6'd1;
            end
            default: skip = 1'b1;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_lfsr   = r_lfsr;
        n_sp     = r_sp;
        n_top    = r_top;
        n_clr    = r_clr;
        n_gen    = r_gen;
        n_nr     = r_nr;
        n_nc     = r_nc;
        n_maddr  = r_maddr;
        n_ov     = r_ov && i_out_stall;
        n_wall   = r_wall;
        n_status = r_status;
        g_we     = 1'b0;
        g_wd     = 1'b0;
        g_waddr  = r_clr;
        g_raddr  = cell_addr(i_row, i_col);
        s_we     = 1'b0;
        s_waddr  = SW'(r_sp - SPW'(1));
        s_raddr  = SW'(r_sp - SPW'(2));

        case (r_state)
            S_CLEAR: begin
                g_we  = 1'b1;
                g_wd  = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(GD - 1)) begin
                    n_clr   = '0;
                    n_state = r_gen ? S_OPEN : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_GEN) begin
                        if (start_bad) begin
                            n_ov = 1'b1; n_wall = 1'b0; n_status = ST_BAD_START;
                        end else begin
                            n_lfsr  = r_seed;
                            n_gen   = 1'b1;
                            n_nr    = i_row;
                            n_nc    = i_col;
                            n_state = S_CLEAR;
                        end
                    end else if (read_bad) begin
                        n_ov = 1'b1; n_wall = 1'b0; n_status = ST_BAD_READ;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_ov     = 1'b1;
                n_wall   = g_rd;
                n_status = ST_OK;
                n_state  = S_IDLE;
            end
            S_OPEN: begin
                g_we    = 1'b1;
                g_wd    = 1'b0;
                g_waddr = cell_addr(r_nr, r_nc);
                n_top   = '{row: r_nr, col: r_nc, j1: l1[0], j2: mod3(l2),
                            j3: l3[1:0], nxt: 3'd0};
                n_lfsr  = l3;
                n_sp    = SPW'(1);
                n_gen   = 1'b0;
                n_state = S_STEP;
            end
            S_STEP: begin
                g_raddr = cell_addr(nr, nc);
                if (r_top.nxt[2]) begin
                    n_sp = r_sp - SPW'(1);
                    if (r_sp == SPW'(1)) begin
                        n_ov = 1'b1; n_wall = 1'b0; n_status = ST_OK;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_POP;
                    end
                end else begin
                    n_top.nxt = r_top.nxt + 3'd1;
                    if (!skip) begin
                        n_nr    = nr;
                        n_nc    = nc;
                        n_maddr = cell_addr(mr, mc);
                        n_state = S_TEST;
                    end
                end
            end
            S_TEST: begin
                // Carve only an unvisited target.
                if (g_rd) begin
                    g_we    = 1'b1;
                    g_wd    = 1'b0;
                    g_waddr = cell_addr(r_nr, r_nc);
                    n_state = S_MID;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_MID: begin
                g_we    = 1'b1;
                g_wd    = 1'b0;
                g_waddr = r_maddr;
                if (r_sp < SPW'(STACK_DEPTH)) begin
                    s_we   = 1'b1;
                    n_top  = '{row: r_nr, col: r_nc, j1: l1[0], j2: mod3(l2),
                               j3: l3[1:0], nxt: 3'd0};
                    n_lfsr = l3;
                    n_sp   = r_sp + SPW'(1);
                end
                n_state = S_STEP;
            end
            S_POP: begin
                n_top   = s_rd;
                n_state = S_STEP;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grid_mem[g_waddr] <= g_wd;
        end
        g_rd <= grid_mem[g_raddr];
        if (s_we) begin
            stack_mem[s_waddr] <= r_top;
        end
        s_rd <= stack_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_size   <= SIZE_RESET;
            r_seed   <= SEED_RESET;
            r_lfsr   <= SEED_RESET;
            r_sp     <= '0;
            r_clr    <= '0;
            r_gen    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lfsr  <= n_lfsr;
            r_sp    <= n_sp;
            r_clr   <= n_clr;
            r_gen   <= n_gen;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_GRID_SIZE) begin
                    r_size <= i_cfg_data[5:0];
                end else if (i_cfg_index == CFG_RANDOM_SEED) begin
                    r_seed <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_nr     <= n_nr;
        r_nc     <= n_nc;
        r_maddr  <= n_maddr;
        r_wall   <= n_wall;
        r_status <= n_status;
    end

    assign o_out_valid = r_ov;
    assign o_wall      = r_wall;
    assign o_status    = r_status;

endmodule

// ===== verif/tb_dfs_maze_carver.sv =====
// Testbench for the maze carver: predicts each cell read and checks every result.
`timescale 1ns / 100ps

module tb_dfs_maze_carver;
    import dfs_pkg::*;

    localparam int SIDE_MAX   = 64;
    localparam int WALK_DEPTH = 1024;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic       command;
        logic [5:0] row;
        logic [5:0] col;
    } t_cmd;

    typedef struct packed {
        logic       wall;
        logic [1:0] status;
    } t_res;

    typedef struct packed {
        logic [5:0] row;
        logic [5:0] col;
        logic [4:0] code;
        logic [2:0] nxt;
    } t_walk;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_command;
    logic [5:0]  i_row;
    logic [5:0]  i_col;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_wall;
    logic [1:0]  o_status;

    dfs_maze_carver DUT (.*);

    // Predictor state
    logic        maze_bits [SIDE_MAX*SIDE_MAX];
    t_walk       walk [WALK_DEPTH];
    int          walk_sp;
    logic [15:0] shuffle_lfsr;
    logic [5:0]  side_cfg;
    logic [15:0] seed_cfg;

    t_cmd  pending_cmds [$];
    t_res  expected_results [$];
    int    errors;
    int    results_seen;
    int    idle_cycles;
    bit    stim_done;
    bit    hold_sender;
    int    burst_left;
    int    gap_left;
    int    stall_phase;
    int    gen_count;
    int    read_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void queue_cmd(input t_cmd x);
        pending_cmds.insert(pending_cmds.size(), x);
    endfunction

    function automatic logic [15:0] next_lfsr();
        logic [15:0] s;
        s = {1'b0, shuffle_lfsr[15:1]};
        if (shuffle_lfsr[0]) begin
            s = s ^ 16'hB400;
        end
        shuffle_lfsr = s;
        return s;
    endfunction

    function automatic logic [4:0] draw_code();
        int a;
        int b;
        int c;
        a = next_lfsr() % 2;
        b = next_lfsr() % 3;
        c = next_lfsr() % 4;
        return 5'(a + 2 * b + 6 * c);
    endfunction

    function automatic int pick_dir(input logic [4:0] code, input int k);
        int a [4];
        int j;
        int t;
        a[0] = 0; a[1] = 1; a[2] = 2; a[3] = 3;
        j = code % 2;       t = a[1]; a[1] = a[j]; a[j] = t;
        j = (code / 2) % 3; t = a[2]; a[2] = a[j]; a[j] = t;
        j = (code / 6) % 4; t = a[3]; a[3] = a[j]; a[j] = t;
        return a[k];
    endfunction

    function automatic void push_walk(input int r, input int c);
        if (walk_sp < WALK_DEPTH) begin
            walk[walk_sp] = '{row: 6'(r), col: 6'(c), code: draw_code(), nxt: 3'd0};
            walk_sp++;
        end
    endfunction

    function automatic void carve_maze(input int side, input int r0, input int c0);
        int r;
        int c;
        int nr;
        int nc;
        int mr;
        int mc;
        int d;
        int top;
        for (int i = 0; i < SIDE_MAX*SIDE_MAX; i++) maze_bits[i] = 1'b1;
        walk_sp = 0;
        maze_bits[r0*SIDE_MAX + c0] = 1'b0;
        push_walk(r0, c0);
        while (walk_sp > 0) begin
            top = walk_sp - 1;
            r = walk[top].row;
            c = walk[top].col;
            if (walk[top].nxt >= 4) begin
                walk_sp = top;
                continue;
            end
            d = pick_dir(walk[top].code, walk[top].nxt);
            walk[top].nxt = walk[top].nxt + 3'd1;
            nr = r; nc = c; mr = r; mc = c;
            if (d == DIR_UP) begin
                if (r <= 2) continue;
                nr = r - 2; mr = r - 1;
            end else if (d == DIR_RIGHT) begin
                if (c + 3 >= side) continue;
                nc = c + 2; mc = c + 1;
            end else if (d == DIR_DOWN) begin
                if (r + 3 >= side) continue;
                nr = r + 2; mr = r + 1;
            end else begin
                if (c <= 2) continue;
                nc = c - 2; mc = c - 1;
            end
            if (maze_bits[nr*SIDE_MAX + nc]) begin
                maze_bits[nr*SIDE_MAX + nc] = 1'b0;
                maze_bits[mr*SIDE_MAX + mc] = 1'b0;
                push_walk(nr, nc);
            end
        end
    endfunction

    function automatic t_res predict_result(input t_cmd x);
        t_res res;
        int side;
        side = (side_cfg < SIDE_MAX) ? side_cfg : SIDE_MAX;
        res = '{wall: 1'b0, status: ST_OK};
        if (x.command == CMD_GEN) begin
            if (!x.row[0] || !x.col[0] || x.row >= side || x.col >= side) begin
                res.status = ST_BAD_START;
            end else begin
                shuffle_lfsr = seed_cfg;
                carve_maze(side, x.row, x.col);
            end
        end else begin
            if (x.row >= side || x.col >= side) begin
                res.status = ST_BAD_READ;
            end else begin
                res.wall = maze_bits[x.row*SIDE_MAX + x.col];
            end
        end
        return res;
    endfunction

    // Driver: bursts and gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            expected_results.insert(expected_results.size(), predict_result(
                '{command: i_command, row: i_row, col: i_col}));
            void'(pending_cmds.pop_front());
            if (i_command == CMD_GEN) gen_count++; else read_count++;
        end
        if (i_in_valid && o_in_stall) begin
            // hold the stalled transaction
        end else if (hold_sender || pending_cmds.size() == 0 ||
                     (i_in_valid && !o_in_stall && pending_cmds.size() == 0)) begin
            i_in_valid <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else begin
            i_in_valid <= 1'b1;
            i_command  <= pending_cmds[0].command;
            i_row      <= pending_cmds[0].row;
            i_col      <= pending_cmds[0].col;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 8);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver stall pattern: stretches of random stalls, stretches of none
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 64;
        if (stall_phase < 24) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Monitor and scoreboard
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, expected_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result wall=%0b status=%0d",
                         $realtime, o_wall, o_status);
            end else begin
                if (o_wall !== expected_results[0].wall) begin
                    errors++;
                    $display("%0t: wall expected %0b actual %0b",
                             $realtime, expected_results[0].wall, o_wall);
                end
                if (o_status !== expected_results[0].status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, expected_results[0].status, o_status);
                end
                void'(expected_results.pop_front());
            end
        end
    end

    task automatic drain_results();
        while (pending_cmds.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_GRID_SIZE) side_cfg = value[5:0];
        else seed_cfg = value;
    endtask

    function automatic t_cmd odd_start(input int side);
        t_cmd x;
        int half;
        half = (side - 1) / 2;
        x.command = CMD_GEN;
        x.row = 6'(2 * $urandom_range(0, half - 1) + 1);
        x.col = 6'(2 * $urandom_range(0, half - 1) + 1);
        return x;
    endfunction

    task automatic add_reads(input int n, input int side);
        t_cmd x;
        for (int i = 0; i < n; i++) begin
            x.command = CMD_READ;
            if ($urandom_range(0, 9) == 0) begin
                x.row = 6'($urandom);
                x.col = 6'($urandom);
            end else begin
                x.row = 6'($urandom_range(0, side - 1));
                x.col = 6'($urandom_range(0, side - 1));
            end
            queue_cmd(x);
        end
    endtask

    initial begin
        int side;
        t_cmd x;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = CFG_GRID_SIZE; i_cfg_data = '0;
        i_in_valid = 1'b0; i_command = CMD_READ; i_row = '0; i_col = '0;
        i_out_stall = 1'b0;
        errors = 0; results_seen = 0; idle_cycles = 0; stim_done = 0;
        hold_sender = 0; burst_left = 0; gap_left = 0; stall_phase = 0;
        gen_count = 0; read_count = 0;
        walk_sp = 0;
        side_cfg = SIZE_RESET; seed_cfg = SEED_RESET; shuffle_lfsr = SEED_RESET;
        for (int i = 0; i < SIDE_MAX*SIDE_MAX; i++) maze_bits[i] = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset grid reads, bad starts, bad reads, extreme cells
        queue_cmd('{CMD_READ, 6'd0, 6'd0});
        queue_cmd('{CMD_READ, 6'd62, 6'd62});
        queue_cmd('{CMD_READ, 6'd63, 6'd0});
        queue_cmd('{CMD_READ, 6'd0, 6'd63});
        queue_cmd('{CMD_GEN, 6'd2, 6'd1});
        queue_cmd('{CMD_GEN, 6'd1, 6'd0});
        queue_cmd('{CMD_GEN, 6'd63, 6'd1});
        queue_cmd('{CMD_GEN, 6'd61, 6'd61});
        queue_cmd('{CMD_READ, 6'd61, 6'd61});
        queue_cmd('{CMD_READ, 6'd62, 6'd61});
        queue_cmd('{CMD_READ, 6'd1, 6'd1});
        queue_cmd('{CMD_READ, 6'd31, 6'd30});
        queue_cmd('{CMD_GEN, 6'd1, 6'd1});
        queue_cmd('{CMD_READ, 6'd1, 6'd2});
        queue_cmd('{CMD_READ, 6'd2, 6'd1});
        queue_cmd('{CMD_READ, 6'd63, 6'd63});
        drain_results();

        // Several settings: small, even, tiny, zero seed, all-ones seed
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin write_reg(CFG_GRID_SIZE, 16'd5); write_reg(CFG_RANDOM_SEED, 16'd1); end
                1: begin write_reg(CFG_GRID_SIZE, 16'd2); write_reg(CFG_RANDOM_SEED, 16'd0); end
                2: begin write_reg(CFG_GRID_SIZE, 16'd8); write_reg(CFG_RANDOM_SEED, 16'hFFFF); end
                3: begin write_reg(CFG_GRID_SIZE, 16'd11); write_reg(CFG_RANDOM_SEED, 16'd0); end
                4: write_reg(CFG_GRID_SIZE, 16'd63);
                default: begin
                    write_reg(CFG_GRID_SIZE, 16'($urandom_range(3, 21)));
                    write_reg(CFG_RANDOM_SEED, 16'($urandom_range(1, 65535)));
                end
            endcase
            side = side_cfg;
            if (phase == 1) begin
                queue_cmd('{CMD_GEN, 6'd1, 6'd1});
                add_reads(4, 2);
            end else begin
                queue_cmd(odd_start(side));
                add_reads(6, side);
                x = '{CMD_GEN, 6'($urandom), 6'($urandom)};
                queue_cmd(x);
                if ($urandom_range(0, 1) == 0) queue_cmd(odd_start(side));
                add_reads(4, side);
            end
            if (phase == 3) begin
                // let the generate get under way, then wait for the block to fall idle
                repeat (40) @(posedge i_clk);
                hold_sender = 1;
                while (expected_results.size() != 0 || i_in_valid) @(posedge i_clk);
                hold_sender = 0;
            end
            drain_results();
        end
        stim_done = 1;
        repeat (20) @(posedge i_clk);

        $display("Covered %0d generates and %0d reads over grid sides 2 to 63, seeds 0 to FFFF",
                 gen_count, read_count);
        $display("%0d results checked, %0d mismatches", results_seen, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
